// ===== rtl/flag_escape_channel_deframer_assert.svh =====
// Assertion macros for the deframer checkers.
`ifndef FLAG_ESCAPE_CHANNEL_DEFRAMER_ASSERT_SVH
`define FLAG_ESCAPE_CHANNEL_DEFRAMER_ASSERT_SVH

// Property checked out of reset.
`define FECD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked during reset as well.
`define FECD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fecd_pkg.sv =====
`timescale 1ns / 1ps

package fecd_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;

  localparam logic [7:0] CTRL_CHANNEL = 8'h00;
  localparam logic [7:0] ACTION_OPEN  = 8'h01;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_OPEN    = 3'b001,
    PH_CHAN    = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  channel;
    logic [7:0]  payload_byte;
    logic        last;
    logic [7:0]  target_channel;
    logic        close_request;
  } result_t;

endpackage

// ===== rtl/fecd_if.sv =====
`timescale 1ns / 1ps

interface fecd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] link_byte;

  modport source (output valid, output link_byte, input ready);
  modport sink   (input valid, input link_byte, output ready);
endinterface

interface fecd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] channel;
  logic [7:0] payload_byte;
  logic       last;
  logic [7:0] target_channel;
  logic       close_request;

  modport source (output valid, output kind, output channel, output payload_byte,
                  output last, output target_channel, output close_request,
                  input ready);
  modport sink   (input valid, input kind, input channel, input payload_byte,
                  input last, input target_channel, input close_request,
                  output ready);
endinterface

// ===== rtl/fecd_in_stage.sv =====
`timescale 1ns / 1ps

module fecd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       word_valid,
  output logic [7:0] word_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign word_valid = valid_r;
  assign word_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== rtl/fecd_core.sv =====
`timescale 1ns / 1ps

module fecd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       link_byte,
  output logic             res_valid,
  output fecd_pkg::result_t res
);

  fecd_pkg::phase_t phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] chan_r, chan_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [1:0] ctrl_cnt_r, ctrl_cnt_nxt;
  logic [7:0] ctrl_tgt_r, ctrl_tgt_nxt;
  logic [7:0] ctrl_act_r, ctrl_act_nxt;
  logic       take;
  logic       close;

  always_comb begin
    phase_nxt      = phase_r;
    esc_nxt        = esc_r;
    chan_nxt       = chan_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    ctrl_cnt_nxt   = ctrl_cnt_r;
    ctrl_tgt_nxt   = ctrl_tgt_r;
    ctrl_act_nxt   = ctrl_act_r;
    take           = 1'b0;
    close          = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    if (fire) begin
      unique case (phase_r)
        fecd_pkg::PH_CHAN: begin
          chan_nxt       = link_byte;
          esc_nxt        = 1'b0;
          held_valid_nxt = 1'b0;
          held_nxt       = 8'h00;
          ctrl_cnt_nxt   = 2'd0;
          ctrl_tgt_nxt   = 8'h00;
          ctrl_act_nxt   = 8'h00;
          phase_nxt      = fecd_pkg::PH_PAYLOAD;
        end
        fecd_pkg::PH_PAYLOAD: begin
          priority if (esc_r) begin
            esc_nxt = 1'b0;
            take    = 1'b1;
          end else if (link_byte == fecd_pkg::ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else if (link_byte == fecd_pkg::FLAG_BYTE) begin
            close = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
        default: begin
          phase_nxt = fecd_pkg::PH_CHAN;
        end
      endcase
    end

    if (take) begin
      priority if (chan_r == fecd_pkg::CTRL_CHANNEL) begin
        if (ctrl_cnt_r == 2'd0) begin
          ctrl_tgt_nxt = link_byte;
          ctrl_cnt_nxt = 2'd1;
        end else if (ctrl_cnt_r == 2'd1) begin
          ctrl_act_nxt = link_byte;
          ctrl_cnt_nxt = 2'd2;
        end
      end else if (held_valid_r) begin
        res_valid        = 1'b1;
        res.kind         = fecd_pkg::KIND_DATA;
        res.channel      = chan_r;
        res.payload_byte = held_r;
        held_nxt         = link_byte;
      end else begin
        held_nxt       = link_byte;
        held_valid_nxt = 1'b1;
      end
    end

    if (close) begin
      phase_nxt = fecd_pkg::PH_OPEN;
      res_valid = 1'b1;
      priority if (chan_r == fecd_pkg::CTRL_CHANNEL) begin
        res.kind           = fecd_pkg::KIND_CTRL;
        res.target_channel = ctrl_tgt_r;
        res.close_request  = (ctrl_act_r != fecd_pkg::ACTION_OPEN);
      end else if (held_valid_r) begin
        res.kind         = fecd_pkg::KIND_DATA;
        res.channel      = chan_r;
        res.payload_byte = held_r;
        res.last         = 1'b1;
        held_valid_nxt   = 1'b0;
      end else begin
        res.kind    = fecd_pkg::KIND_EMPTY;
        res.channel = chan_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fecd_pkg::PH_OPEN;
      esc_r        <= 1'b0;
      chan_r       <= 8'h00;
      held_r       <= 8'h00;
      held_valid_r <= 1'b0;
      ctrl_cnt_r   <= 2'd0;
      ctrl_tgt_r   <= 8'h00;
      ctrl_act_r   <= 8'h00;
    end else begin
      phase_r      <= phase_nxt;
      esc_r        <= esc_nxt;
      chan_r       <= chan_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      ctrl_cnt_r   <= ctrl_cnt_nxt;
      ctrl_tgt_r   <= ctrl_tgt_nxt;
      ctrl_act_r   <= ctrl_act_nxt;
    end
  end

endmodule

// ===== rtl/fecd_out_stage.sv =====
`timescale 1ns / 1ps

module fecd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  fecd_pkg::result_t res,
  output logic              advance,
  fecd_out_if.source        out_ch
);

  logic              valid_r;
  fecd_pkg::result_t res_r;

  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.channel        = res_r.channel;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.last           = res_r.last;
  assign out_ch.target_channel = res_r.target_channel;
  assign out_ch.close_request  = res_r.close_request;

endmodule

// ===== rtl/flag_escape_channel_deframer.sv =====
`timescale 1ns / 1ps
// Byte-stuffed link deframer.
// in_ch takes one raw link byte per word (valid/ready). A frame is an opening
// byte of any value, a raw channel byte, escaped payload (0x7D makes the next
// byte literal) and a closing 0x7E.
// out_ch gives one word per data payload byte (held back one byte so the
// final one carries last), one word per control frame (channel 0: target and
// close_request from the first two payload bytes) or one empty-frame word.
// Path: a byte accepted into the input register is decoded into the result
// register once that register advances, and any word it yields shows from there.
// Throughput: one byte per clock unless out_ch.ready stalls; decoding is
// one pass through frame state registers between input and result registers.
// Reset (rst_n low, synchronous) empties both registers and puts the
// deframer back to waiting for an opening byte.
// When out_ch.ready is low with a word waiting, the result register holds,
// one more byte may sit in the input register, then in_ch.ready drops.
module flag_escape_channel_deframer (
  input  logic       clk,
  input  logic       rst_n,
  fecd_in_if.sink    in_ch,
  fecd_out_if.source out_ch
);

  logic              advance;
  logic              word_valid;
  logic [7:0]        word_byte;
  logic              res_valid;
  fecd_pkg::result_t res;

  fecd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.link_byte),
    .advance    (advance),
    .word_valid (word_valid),
    .word_byte  (word_byte)
  );

  fecd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (word_valid && advance),
    .link_byte (word_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fecd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/fecd_checker.sv =====
`timescale 1ns / 1ps
`include "flag_escape_channel_deframer_assert.svh"

module fecd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_channel,
  input logic [7:0] out_payload_byte,
  input logic       out_last,
  input logic [7:0] out_target_channel,
  input logic       out_close_request
);

  `FECD_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "word shown after reset")
  `FECD_ASSERT(a_hold_on_stall, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_payload_byte) && $stable(out_last), "word changed while stalled")
  `FECD_ASSERT(a_ctrl_fields, out_valid && out_kind == fecd_pkg::KIND_CTRL |-> out_channel == fecd_pkg::CTRL_CHANNEL && !out_last && out_payload_byte == 8'h00, "control word carries data fields")
  `FECD_ASSERT(a_data_fields, out_valid && out_kind != fecd_pkg::KIND_CTRL |-> out_channel != fecd_pkg::CTRL_CHANNEL && out_target_channel == 8'h00 && !out_close_request, "data word on control channel")

endmodule

bind flag_escape_channel_deframer fecd_checker u_fecd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_channel        (out_ch.channel),
  .out_payload_byte   (out_ch.payload_byte),
  .out_last           (out_ch.last),
  .out_target_channel (out_ch.target_channel),
  .out_close_request  (out_ch.close_request)
);
